// File: hdl/sfe_pkg.sv
`default_nettype none
package sfe_pkg;

  localparam logic [7:0] SyncFirst  = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;
  localparam logic [7:0] StuffByte  = 8'h00;
  localparam logic [7:0] LenExtra   = 8'd4;

  // largest number of symbols one request can produce (five header bytes plus checksum)
  localparam int unsigned SymMax  = 6;
  localparam int unsigned SymCntW = $clog2(SymMax + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  // one frame symbol before byte stuffing
  typedef struct packed {
    logic [7:0] data;
    logic       stuff;   // symbol is subject to stuffing after 0xAA
    logic       fend;    // symbol closes the frame
    logic       err;     // sequence error marker
  } sym_t;

  typedef sym_t [SymMax-1:0] sym_vec_t;

  // handoff from builder to emitter
  typedef struct packed {
    logic               valid;
    logic [SymCntW-1:0] cnt;
    sym_vec_t           syms;
  } sfe_load_t;

endpackage
`default_nettype wire

// File: hdl/sfe_in_if.sv
`default_nettype none
interface sfe_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] msg_length;
  logic [7:0] device_id;
  logic [7:0] msg_type;
  logic [7:0] data_byte;

  modport source (
    output valid, command, msg_length, device_id, msg_type, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, msg_length, device_id, msg_type, data_byte,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/sfe_out_if.sv
`default_nettype none
interface sfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic       seq_error;

  modport source (
    output valid, out_byte, run_last, frame_end, seq_error,
    input  ready
  );
  modport sink (
    input  valid, out_byte, run_last, frame_end, seq_error,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/sfe_builder.sv
`default_nettype none
module sfe_builder
  import sfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sfe_in_if.sink    in_chan,
  input  wire logic load_ready,
  output sfe_load_t load
);

  logic       valid_r, valid_nxt;
  logic       cmd_r;
  logic [7:0] len_r, id_r, typ_r, db_r;

  logic [7:0] sum_r, sum_nxt;
  logic [7:0] left_r, left_nxt;
  logic       open_r, open_nxt;

  logic       commit;
  logic [7:0] len_byte;
  logic [7:0] hdr_sum;
  logic [7:0] data_sum;
  logic [7:0] left_dec;

  assign commit        = valid_r && load_ready;
  assign in_chan.ready = !valid_r || load_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      cmd_r  <= in_chan.command;
      len_r  <= in_chan.msg_length;
      id_r   <= in_chan.device_id;
      typ_r  <= in_chan.msg_type;
      db_r   <= in_chan.data_byte;
    end
  end

  assign len_byte = len_r + LenExtra;
  assign hdr_sum  = len_byte + id_r + typ_r;
  assign data_sum = sum_r + db_r;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    sum_nxt    = sum_r;
    left_nxt   = left_r;
    open_nxt   = open_r;
    load.valid = commit;
    load.cnt   = '0;
    load.syms  = '0;
    unique case (cmd_t'(cmd_r))
      CMD_START: begin
        load.syms[0] = '{data: SyncFirst,  stuff: 1'b0, fend: 1'b0, err: 1'b0};
        load.syms[1] = '{data: SyncSecond, stuff: 1'b0, fend: 1'b0, err: 1'b0};
        load.syms[2] = '{data: len_byte,   stuff: 1'b1, fend: 1'b0, err: 1'b0};
        load.syms[3] = '{data: id_r,       stuff: 1'b1, fend: 1'b0, err: 1'b0};
        load.syms[4] = '{data: typ_r,      stuff: 1'b1, fend: 1'b0, err: 1'b0};
        if (len_r == 8'd0) begin
          // empty payload closes the frame right after the header
          load.syms[5] = '{data: hdr_sum, stuff: 1'b1, fend: 1'b1, err: 1'b0};
          load.cnt     = SymCntW'(6);
          sum_nxt      = '0;
          left_nxt     = '0;
          open_nxt     = 1'b0;
        end else begin
          load.cnt = SymCntW'(5);
          sum_nxt  = hdr_sum;
          left_nxt = len_r;
          open_nxt = 1'b1;
        end
      end
      CMD_DATA: begin
        if (!open_r) begin
          load.syms[0] = '{data: 8'd0, stuff: 1'b0, fend: 1'b0, err: 1'b1};
          load.cnt     = SymCntW'(1);
        end else begin
          load.syms[0] = '{data: db_r, stuff: 1'b1, fend: 1'b0, err: 1'b0};
          if (left_dec == 8'd0) begin
            load.syms[1] = '{data: data_sum, stuff: 1'b1, fend: 1'b1, err: 1'b0};
            load.cnt     = SymCntW'(2);
            sum_nxt      = '0;
            left_nxt     = '0;
            open_nxt     = 1'b0;
          end else begin
            load.cnt = SymCntW'(1);
            sum_nxt  = data_sum;
            left_nxt = left_dec;
          end
        end
      end
      default: begin
        load.cnt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      left_r <= '0;
      open_r <= 1'b0;
    end else if (commit) begin
      sum_r  <= sum_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/sfe_emitter.sv
`default_nettype none
module sfe_emitter
  import sfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sfe_load_t load,
  output logic           load_ready,
  sfe_out_if.source      out_chan
);

  sym_vec_t           q_r, q_nxt;
  logic [SymCntW-1:0] cnt_r, cnt_nxt;
  logic               stuff_r, stuff_nxt;

  sym_t head;
  logic need_stuff;
  logic head_done;
  logic fire;

  assign head       = q_r[0];
  assign need_stuff = head.stuff && (head.data == SyncFirst);
  assign head_done  = !need_stuff || stuff_r;
  assign fire       = out_chan.valid && out_chan.ready;

  assign out_chan.valid     = (cnt_r != '0);
  assign out_chan.out_byte  = stuff_r ? StuffByte : head.data;
  assign out_chan.run_last  = head_done && (cnt_r == SymCntW'(1));
  assign out_chan.frame_end = head.fend && head_done;
  assign out_chan.seq_error = head.err;

  // free once the last byte of the current request leaves
  assign load_ready = (cnt_r == '0) ||
                      ((cnt_r == SymCntW'(1)) && head_done && out_chan.ready);

  always_comb begin
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    stuff_nxt = stuff_r;
    if (load.valid) begin
      q_nxt     = load.syms;
      cnt_nxt   = load.cnt;
      stuff_nxt = 1'b0;
    end else if (fire) begin
      if (head_done) begin
        q_nxt     = {sym_t'('0), q_r[SymMax-1:1]};
        cnt_nxt   = cnt_r - SymCntW'(1);
        stuff_nxt = 1'b0;
      end else begin
        stuff_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      stuff_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      stuff_r <= stuff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/stuffed_frame_encoder_unit.sv
`default_nettype none
// Serial-link frame builder with byte stuffing and an 8-bit additive checksum.
// A start request (command 0) emits AA 55, then msg_length+4, device_id and
// msg_type; with a zero length the checksum follows at once and the frame is
// closed. Each data request (command 1) emits its payload byte, and the one
// that completes the payload also emits the checksum (wrapping sum of the
// length byte, id, type and payload). Every 0xAA other than the sync byte is
// followed by a stuffed 0x00. A data request with no frame open yields one
// byte 0x00 with seq_error set and is otherwise dropped; a start request on
// an open frame abandons it. The output moves one byte per cycle while
// out_chan.ready is high. A request produces 1 or 2 bytes for a plain
// payload byte, up to 4 for the last one and 5 to 9 for a start. The next
// request is taken into the input register while the current bytes drain,
// and hands over on the cycle the last byte is taken, so payload bytes
// without stuffing stream at one request per cycle while ready is high.
module stuffed_frame_encoder_unit
  import sfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sfe_in_if.sink    in_chan,
  sfe_out_if.source out_chan
);

  // symbol list of one request, handed from builder to emitter
  sfe_load_t load;
  logic      load_ready;

  // input register, frame state and symbol generation
  sfe_builder u_builder (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .load_ready (load_ready),
    .load       (load)
  );

  // symbol queue, stuffing insertion and output handshake
  sfe_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_ready (load_ready),
    .out_chan   (out_chan)
  );

endmodule
`default_nettype wire
